### rtl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared types and codes of the hashed vote tally: item layouts, request and
// status codes, configuration register indexes and default sizes.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int unsigned VOTER_SLOTS_DEF   = 1024;
  localparam int unsigned CAND_SLOTS_DEF    = 16;
  localparam int unsigned KEY_PART_BITS_DEF = 32;

  localparam int unsigned VOTE_W   = 11;
  localparam int unsigned VSIZE_W  = 11;
  localparam int unsigned CSIZE_W  = 5;
  localparam int unsigned CFG_W    = 11;

  localparam logic [VOTE_W-1:0]  VOTE_MAX       = 11'd2047;
  localparam logic [VSIZE_W-1:0] VSIZE_RESET    = 11'd1024;
  localparam logic [CSIZE_W-1:0] CSIZE_RESET    = 5'd16;

  localparam logic [1:0] REQ_ADD_VOTER = 2'd0;
  localparam logic [1:0] REQ_ADD_CAND  = 2'd1;
  localparam logic [1:0] REQ_DECLARE   = 2'd2;
  localparam logic [1:0] REQ_QUERY     = 2'd3;

  localparam logic [1:0] ST_WINNER   = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic CFG_VOTER_SIZE = 1'b0;
  localparam logic CFG_CAND_SIZE  = 1'b1;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key_val;
    logic [31:0] key_mod;
    logic [31:0] choice_val;
    logic [31:0] choice_mod;
  } req_t;

  typedef struct packed {
    logic [31:0]       winner_val;
    logic [31:0]       winner_mod;
    logic [VOTE_W-1:0] winner_votes;
    logic [1:0]        status;
  } res_t;

endpackage

### rtl/hvt_ram.sv
// ----------------------------------------------------------------------------
// hvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/hvt_mod.sv
// ----------------------------------------------------------------------------
// hvt_mod
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module hvt_mod #(
  parameter int unsigned NW = 33,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned CNW = $clog2(NW + 1);

  logic [NW-1:0]  num_q;
  logic [DW-1:0]  den_q;
  logic [DW-1:0]  rem_q, rem_d;
  logic [CNW-1:0] cnt_q;
  logic           done_q;
  logic [DW:0]    trial;
  logic [DW:0]    diff;

  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    rem_d = (trial >= {1'b0, den_q}) ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q <= num_i;
        den_q <= den_i;
        rem_q <= '0;
        cnt_q <= CNW'(NW);
      end else if (cnt_q != '0) begin
        num_q  <= num_q << 1;
        rem_q  <= rem_d;
        cnt_q  <= cnt_q - CNW'(1);
        done_q <= (cnt_q == CNW'(1));
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### rtl/hashed_vote_tally_core.sv
// ----------------------------------------------------------------------------
// hashed_vote_tally_core
// Vote tally over two linear-probing hash tables held in RAM.
// ----------------------------------------------------------------------------
// One item at a time. Add voter, add candidate and declaration items run the
// serial hash remainder, then a RAM read and a compare for each probed slot; a
// declaration by a fresh voter runs a second probe on the candidate table. A
// query reads and compares every candidate slot of the configured size, then
// runs a clearing pass over all VOTER_SLOTS voter RAM entries, one per cycle,
// during which no item is taken. The same pass runs after reset.
// Configuration writes are taken at any time.
module hashed_vote_tally_core #(
  parameter int unsigned VOTER_SLOTS     = hvt_pkg::VOTER_SLOTS_DEF,
  parameter int unsigned CANDIDATE_SLOTS = hvt_pkg::CAND_SLOTS_DEF,
  parameter int unsigned KEY_PART_BITS   = hvt_pkg::KEY_PART_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hvt_pkg::req_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hvt_pkg::res_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [hvt_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int unsigned K   = KEY_PART_BITS;
  localparam int unsigned KW  = 2 * K;
  localparam int unsigned MAXS = (VOTER_SLOTS > CANDIDATE_SLOTS) ? VOTER_SLOTS
                                                                 : CANDIDATE_SLOTS;
  localparam int unsigned SW  = $clog2(MAXS + 1);
  localparam int unsigned VIW = (VOTER_SLOTS > 1) ? $clog2(VOTER_SLOTS) : 1;
  localparam int unsigned CIW = (CANDIDATE_SLOTS > 1) ? $clog2(CANDIDATE_SLOTS) : 1;
  localparam int unsigned VW  = KW + 2;
  localparam int unsigned CW  = KW + hvt_pkg::VOTE_W;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH_GO, S_HASH, S_RD, S_CMP, S_SCAN_RD, S_SCAN_CMP, S_DONE
  } state_e;

  state_e                        state_q;
  hvt_pkg::req_t                 req_q;
  logic                          tbl_q;
  logic [KW-1:0]                 pkey_q;
  logic [SW-1:0]                 slot_q, cnt_q, vmin_q;
  logic [hvt_pkg::VSIZE_W-1:0]   vsize_q;
  logic [hvt_pkg::CSIZE_W-1:0]   csize_q;
  logic [CANDIDATE_SLOTS-1:0]    cand_used_q;
  logic                          any_decl_q, ovf_q, have_c_q, best_vld_q;
  logic [hvt_pkg::VOTE_W-1:0]    best_votes_q;
  logic [KW-1:0]                 best_key_q;
  logic                          out_valid_q;
  hvt_pkg::res_t                 out_q;

  logic [SW-1:0]   vs, cs, cur_size, nxt_slot;
  logic            v_we, c_we;
  logic [VW-1:0]   v_wdata, v_rdata;
  logic [CW-1:0]   c_wdata, c_rdata;
  logic            v_used, v_voted, c_used_bit, ent_used, hit, empty, last;
  logic [KW-1:0]   v_key, c_key, ent_key;
  logic [hvt_pkg::VOTE_W-1:0] c_votes;
  logic            is_insert, is_decl, have_v;
  logic [1:0]      status;
  logic            mod_start, mod_done;
  logic [K:0]      mod_num;
  logic [SW-1:0]   mod_rem;

  always_comb begin
    vs = (vsize_q == '0) ? SW'(1)
       : (32'(vsize_q) > 32'(VOTER_SLOTS)) ? SW'(VOTER_SLOTS) : SW'(vsize_q);
    cs = (csize_q == '0) ? SW'(1)
       : (32'(csize_q) > 32'(CANDIDATE_SLOTS)) ? SW'(CANDIDATE_SLOTS) : SW'(csize_q);
    cur_size = tbl_q ? cs : vs;
    nxt_slot = ((slot_q + SW'(1)) == cur_size) ? '0 : slot_q + SW'(1);

    v_voted    = v_rdata[VW-1];
    v_used     = v_rdata[VW-2];
    v_key      = v_rdata[KW-1:0];
    c_key      = c_rdata[KW-1:0];
    c_votes    = c_rdata[CW-1:KW];
    c_used_bit = cand_used_q[slot_q[CIW-1:0]];
    ent_used   = tbl_q ? c_used_bit : v_used;
    ent_key    = tbl_q ? c_key : v_key;
    hit        = ent_used && (ent_key == pkey_q);
    empty      = !ent_used;
    last       = (cnt_q + SW'(1)) == cur_size;

    is_insert = (req_q.req_type == hvt_pkg::REQ_ADD_VOTER) ||
                (req_q.req_type == hvt_pkg::REQ_ADD_CAND);
    is_decl   = (req_q.req_type == hvt_pkg::REQ_DECLARE);

    v_we    = 1'b0;
    v_wdata = '0;
    c_we    = 1'b0;
    c_wdata = {{hvt_pkg::VOTE_W{1'b0}}, pkey_q};
    if (state_q == S_INIT) begin
      v_we = 1'b1;
    end else if (state_q == S_CMP && !tbl_q) begin
      if (is_insert && empty) begin
        v_we    = 1'b1;
        v_wdata = {1'b0, 1'b1, pkey_q};
      end else if (is_decl && hit && !v_voted) begin
        v_we    = 1'b1;
        v_wdata = {1'b1, 1'b1, pkey_q};
      end
    end
    if (state_q == S_CMP && tbl_q) begin
      if (is_insert && empty) begin
        c_we = 1'b1;
      end else if (is_decl && hit && c_votes < hvt_pkg::VOTE_MAX) begin
        c_we    = 1'b1;
        c_wdata = {c_votes + hvt_pkg::VOTE_W'(1), pkey_q};
      end
    end

    mod_start = (state_q == S_HASH_GO);
    mod_num   = {1'b0, pkey_q[KW-1:K]} + {1'b0, pkey_q[K-1:0]};

    have_v = vmin_q < vs;
    if (ovf_q) begin
      status = hvt_pkg::ST_OVERFLOW;
    end else if (!have_v || !have_c_q || !any_decl_q) begin
      status = hvt_pkg::ST_EMPTY;
    end else begin
      status = hvt_pkg::ST_WINNER;
    end
  end

  hvt_mod #(.NW(K + 1), .DW(SW)) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (mod_num),
    .den_i   (cur_size),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  hvt_ram #(.WIDTH(VW), .DEPTH(VOTER_SLOTS)) u_voter_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (slot_q[VIW-1:0]),
    .wdata_i (v_wdata),
    .raddr_i (slot_q[VIW-1:0]),
    .rdata_o (v_rdata)
  );

  hvt_ram #(.WIDTH(CW), .DEPTH(CANDIDATE_SLOTS)) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (slot_q[CIW-1:0]),
    .wdata_i (c_wdata),
    .raddr_i (slot_q[CIW-1:0]),
    .rdata_o (c_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      req_q        <= '0;
      tbl_q        <= 1'b0;
      pkey_q       <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      vmin_q       <= SW'(VOTER_SLOTS);
      vsize_q      <= hvt_pkg::VSIZE_RESET;
      csize_q      <= hvt_pkg::CSIZE_RESET;
      cand_used_q  <= '0;
      any_decl_q   <= 1'b0;
      ovf_q        <= 1'b0;
      have_c_q     <= 1'b0;
      best_vld_q   <= 1'b0;
      best_votes_q <= '0;
      best_key_q   <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          hvt_pkg::CFG_VOTER_SIZE: vsize_q <= cfg_data_i;
          hvt_pkg::CFG_CAND_SIZE:  csize_q <= cfg_data_i[hvt_pkg::CSIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          if (slot_q == SW'(VOTER_SLOTS - 1)) begin
            slot_q  <= '0;
            state_q <= S_IDLE;
          end else begin
            slot_q <= slot_q + SW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            if (in_data_i.req_type == hvt_pkg::REQ_QUERY) begin
              slot_q     <= '0;
              have_c_q   <= 1'b0;
              best_vld_q <= 1'b0;
              state_q    <= S_SCAN_RD;
            end else begin
              tbl_q   <= (in_data_i.req_type == hvt_pkg::REQ_ADD_CAND);
              pkey_q  <= {in_data_i.key_val[K-1:0], in_data_i.key_mod[K-1:0]};
              if (in_data_i.req_type == hvt_pkg::REQ_DECLARE) begin
                any_decl_q <= 1'b1;
              end
              state_q <= S_HASH_GO;
            end
          end
        end
        S_HASH_GO: state_q <= S_HASH;
        S_HASH: begin
          if (mod_done) begin
            slot_q  <= mod_rem;
            cnt_q   <= '0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (empty) begin
            if (is_insert) begin
              if (tbl_q) begin
                cand_used_q[slot_q[CIW-1:0]] <= 1'b1;
              end else if (slot_q < vmin_q) begin
                vmin_q <= slot_q;
              end
            end
            state_q <= S_IDLE;
          end else if (hit) begin
            if (is_decl && !tbl_q && !v_voted) begin
              tbl_q   <= 1'b1;
              pkey_q  <= {req_q.choice_val[K-1:0], req_q.choice_mod[K-1:0]};
              state_q <= S_HASH_GO;
            end else begin
              state_q <= S_IDLE;
            end
          end else if (last) begin
            if (is_insert) begin
              ovf_q <= 1'b1;
            end
            state_q <= S_IDLE;
          end else begin
            slot_q  <= nxt_slot;
            cnt_q   <= cnt_q + SW'(1);
            state_q <= S_RD;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (c_used_bit) begin
            have_c_q <= 1'b1;
            if (!best_vld_q || c_votes > best_votes_q) begin
              best_vld_q   <= 1'b1;
              best_votes_q <= c_votes;
              best_key_q   <= c_key;
            end
          end
          if ((slot_q + SW'(1)) == cs) begin
            state_q <= S_DONE;
          end else begin
            slot_q  <= slot_q + SW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q.status <= status;
            if (status == hvt_pkg::ST_WINNER && best_vld_q) begin
              out_q.winner_val   <= 32'(best_key_q[KW-1:K]);
              out_q.winner_mod   <= 32'(best_key_q[K-1:0]);
              out_q.winner_votes <= best_votes_q;
            end else begin
              out_q.winner_val   <= '0;
              out_q.winner_mod   <= '0;
              out_q.winner_votes <= '0;
            end
            cand_used_q <= '0;
            any_decl_q  <= 1'b0;
            ovf_q       <= 1'b0;
            vmin_q      <= SW'(VOTER_SLOTS);
            slot_q      <= '0;
            state_q     <= S_INIT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (cnt_q < cur_size && slot_q < cur_size))
    else $error("probe ran past table size");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CMP) |-> (slot_q < cs))
    else $error("winner scan ran past table size");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_DONE))
    else $error("result raised outside query completion");

  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (!in_ready_o && v_we))
    else $error("item taken during clearing pass");

endmodule

### test/hashed_vote_tally_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_vote_tally_core_tb
// Self-checking bench for the vote tally core. A behavioral tally tracks both
// hash tables and predicts every query result, which the result monitor
// compares field by field. Directed corner cases come first, then random
// election rounds under several table sizes with random idling on both sides.
// ----------------------------------------------------------------------------
module hashed_vote_tally_core_tb;

  localparam int VSLOTS = 1024;
  localparam int CSLOTS = 16;
  localparam int DRAIN = 2 * VSLOTS + 200;
  localparam longint LIMIT = 64'd6000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  hvt_pkg::req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  hvt_pkg::res_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [hvt_pkg::CFG_W-1:0] cfg_data_i = '0;

  hashed_vote_tally_core DUT (.*);

  always #4 clk_i = ~clk_i;

  logic [10:0] vsize_reg;
  logic [4:0] csize_reg;
  logic [63:0] vkey[VSLOTS];
  bit vused[VSLOTS];
  bit vvoted[VSLOTS];
  logic [63:0] ckey[CSLOTS];
  bit cused[CSLOTS];
  logic [10:0] cvotes[CSLOTS];
  bit declared;
  bit overflowed;

  hvt_pkg::res_t winners_q[$];
  int errors = 0;
  int queries = 0;
  int items = 0;
  longint cycles = 0;
  bit no_idle = 0;
  int hold_off = 0;
  logic [31:0] pool_v[8];
  logic [31:0] pool_m[8];

  function automatic int eff(int r, int slots);
    if (r == 0) return 1;
    if (r > slots) return slots;
    return r;
  endfunction

  function automatic void wipe_tables();
    foreach (vused[i]) begin
      vused[i] = 0;
      vvoted[i] = 0;
    end
    foreach (cused[i]) begin
      cused[i] = 0;
      cvotes[i] = '0;
    end
    declared = 0;
    overflowed = 0;
  endfunction

  function automatic int find_slot(bit is_cand, int size, logic [31:0] v, logic [31:0] m,
                                   output int free_s);
    logic [32:0] sum;
    logic [63:0] k;
    int h, s;
    sum = {1'b0, v} + {1'b0, m};
    h = int'(sum % size);
    k = {v, m};
    free_s = -1;
    for (int i = 0; i < size; i++) begin
      s = (h + i) % size;
      if (!(is_cand ? cused[s] : vused[s])) begin
        free_s = s;
        return -1;
      end
      if ((is_cand ? ckey[s] : vkey[s]) == k) return s;
    end
    return -1;
  endfunction

  function automatic void tally_item(hvt_pkg::req_t r);
    int vs, cs, fs, vi, ci, best;
    bit have_v, have_c;
    hvt_pkg::res_t w;
    vs = eff(int'(vsize_reg), VSLOTS);
    cs = eff(int'(csize_reg), CSLOTS);
    case (r.req_type) inside
      hvt_pkg::REQ_ADD_VOTER, hvt_pkg::REQ_ADD_CAND: begin
        bit c;
        c = (r.req_type == hvt_pkg::REQ_ADD_CAND);
        if (find_slot(c, c ? cs : vs, r.key_val, r.key_mod, fs) < 0) begin
          if (fs < 0) overflowed = 1;
          else if (c) begin
            ckey[fs] = {r.key_val, r.key_mod};
            cused[fs] = 1;
          end else begin
            vkey[fs] = {r.key_val, r.key_mod};
            vused[fs] = 1;
          end
        end
      end
      hvt_pkg::REQ_DECLARE: begin
        declared = 1;
        vi = find_slot(0, vs, r.key_val, r.key_mod, fs);
        if (vi >= 0 && !vvoted[vi]) begin
          vvoted[vi] = 1;
          ci = find_slot(1, cs, r.choice_val, r.choice_mod, fs);
          if (ci >= 0 && cvotes[ci] != hvt_pkg::VOTE_MAX) cvotes[ci]++;
        end
      end
      default: begin
        have_v = 0;
        have_c = 0;
        best = -1;
        for (int i = 0; i < vs; i++) if (vused[i]) have_v = 1;
        for (int i = 0; i < cs; i++)
          if (cused[i]) begin
            have_c = 1;
            if (best < 0 || cvotes[i] > cvotes[best]) best = i;
          end
        w = '0;
        if (overflowed) w.status = hvt_pkg::ST_OVERFLOW;
        else if (!have_v || !have_c || !declared) w.status = hvt_pkg::ST_EMPTY;
        else begin
          w.status = hvt_pkg::ST_WINNER;
          w.winner_val = ckey[best][63:32];
          w.winner_mod = ckey[best][31:0];
          w.winner_votes = cvotes[best];
        end
        winners_q.push_back(w);
        wipe_tables();
      end
    endcase
  endfunction

  task automatic idle_gap();
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
  endtask

  task automatic send_item(logic [1:0] t, logic [31:0] kv, logic [31:0] km,
                           logic [31:0] cv = '0, logic [31:0] cm = '0);
    hvt_pkg::req_t r;
    r.req_type = t;
    r.key_val = kv;
    r.key_mod = km;
    r.choice_val = cv;
    r.choice_mod = cm;
    idle_gap();
    in_data_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tally_item(r);
    items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (winners_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [hvt_pkg::CFG_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == hvt_pkg::CFG_VOTER_SIZE) vsize_reg = val[10:0];
    else csize_reg = val[4:0];
    @(negedge clk_i);
  endtask

  task automatic set_sizes(logic [hvt_pkg::CFG_W-1:0] v, logic [hvt_pkg::CFG_W-1:0] c);
    wait_drained();
    write_reg(hvt_pkg::CFG_VOTER_SIZE, v);
    write_reg(hvt_pkg::CFG_CAND_SIZE, c);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("FAILURE");
      $finish;
    end
    if (out_valid_o && out_ready_i) begin
      if (winners_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        hvt_pkg::res_t e;
        e = winners_q.pop_front();
        queries++;
        if (out_data_o.winner_val !== e.winner_val)
          $display("%0t winner_val exp %h got %h", $time, e.winner_val, out_data_o.winner_val);
        if (out_data_o.winner_mod !== e.winner_mod)
          $display("%0t winner_mod exp %h got %h", $time, e.winner_mod, out_data_o.winner_mod);
        if (out_data_o.winner_votes !== e.winner_votes)
          $display("%0t winner_votes exp %0d got %0d", $time, e.winner_votes,
                   out_data_o.winner_votes);
        if (out_data_o.status !== e.status)
          $display("%0t status exp %0d got %0d", $time, e.status, out_data_o.status);
        if (out_data_o !== e) errors++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      hold_off = $urandom_range(0, 4);
      out_ready_i <= 1'b0;
    end else out_ready_i <= 1'b1;
  end

  task automatic test_directed();
    send_item(hvt_pkg::REQ_QUERY, '0, '0);
    send_item(hvt_pkg::REQ_ADD_VOTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(hvt_pkg::REQ_ADD_VOTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(hvt_pkg::REQ_ADD_VOTER, '0, '0);
    send_item(hvt_pkg::REQ_ADD_VOTER, 32'd5, 32'd7);
    send_item(hvt_pkg::REQ_ADD_CAND, 32'hFFFF_FFFF, 32'h0000_0001);
    send_item(hvt_pkg::REQ_ADD_CAND, 32'd16, 32'd0);
    send_item(hvt_pkg::REQ_DECLARE, 32'd99, 32'd1, 32'd16, 32'd0);
    send_item(hvt_pkg::REQ_DECLARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd16, 32'd0);
    send_item(hvt_pkg::REQ_DECLARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    send_item(hvt_pkg::REQ_DECLARE, '0, '0, 32'd1, 32'd2);
    send_item(hvt_pkg::REQ_QUERY, '0, '0);
    send_item(hvt_pkg::REQ_ADD_VOTER, 32'd1, 32'd1);
    send_item(hvt_pkg::REQ_ADD_CAND, 32'd2, 32'd2);
    send_item(hvt_pkg::REQ_ADD_CAND, 32'd3, 32'd3);
    send_item(hvt_pkg::REQ_DECLARE, 32'd1, 32'd1, 32'd9, 32'd9);
    send_item(hvt_pkg::REQ_QUERY, '0, '0);
    set_sizes(11'd0, 11'd0);
    send_item(hvt_pkg::REQ_ADD_VOTER, 32'd4, 32'd4);
    send_item(hvt_pkg::REQ_ADD_VOTER, 32'd5, 32'd5);
    send_item(hvt_pkg::REQ_ADD_CAND, 32'd6, 32'd6);
    send_item(hvt_pkg::REQ_DECLARE, 32'd4, 32'd4, 32'd6, 32'd6);
    send_item(hvt_pkg::REQ_QUERY, '0, '0);
    set_sizes(11'h7FF, 11'h7FF);
  endtask

  task automatic send_round(int nv, int nc, int nd);
    logic [31:0] kv, km;
    for (int i = 0; i < 8; i++) begin
      pool_v[i] = $urandom();
      pool_m[i] = $urandom();
    end
    repeat (nv) begin
      kv = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40);
      km = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40);
      send_item(hvt_pkg::REQ_ADD_VOTER, kv, km);
    end
    repeat (nc) begin
      int p;
      p = $urandom_range(0, 7);
      send_item(hvt_pkg::REQ_ADD_CAND, pool_v[p], pool_m[p]);
    end
    repeat (nd) begin
      int p;
      p = $urandom_range(0, 7);
      kv = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 40);
      km = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 40);
      send_item(hvt_pkg::REQ_DECLARE, kv, km, pool_v[p], pool_m[p]);
    end
    if ($urandom_range(0, 4) == 0)
      send_item(2'($urandom_range(0, 2)), $urandom(), $urandom(), $urandom(), $urandom());
    send_item(hvt_pkg::REQ_QUERY, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_random_rounds(int n);
    repeat (n) send_round($urandom_range(0, 30), $urandom_range(0, 6), $urandom_range(0, 40));
  endtask

  task automatic test_small_tables();
    set_sizes(11'd3, 11'd2);
    repeat (10) send_round($urandom_range(1, 6), $urandom_range(1, 4), $urandom_range(1, 10));
    set_sizes(11'd1, 11'd1);
    repeat (6) send_round($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 4));
  endtask

  task automatic test_backpressure();
    hold_off = 4000;
    repeat (4) send_round(3, 2, 4);
    wait_drained();
  endtask

  initial begin
    vsize_reg = hvt_pkg::VSIZE_RESET;
    csize_reg = hvt_pkg::CSIZE_RESET;
    wipe_tables();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_rounds(14);
    test_small_tables();
    set_sizes(11'd1024, 11'd16);
    test_backpressure();
    set_sizes(11'd700, 11'd13);
    test_random_rounds(11);
    no_idle = 1;
    test_random_rounds(8);
    wait_drained();
    $display("Covered %0d items and %0d queries over several table sizes,", items, queries);
    $display("including duplicate keys, overflow, saturating corners and long output stalls.");
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
